/* src/qsls_pkg.sv */
`default_nettype none

package qsls_pkg;

  // Default sizing of the store.
  localparam int DEPTH_DEFAULT       = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // Fixed field widths of the channels.
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
  localparam logic [OP_W-1:0] OP_TAKE_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_TAKE_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

`default_nettype wire

/* src/qsls_mem.sv */
`default_nettype none

module qsls_mem #(
  parameter int DEPTH = qsls_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = qsls_pkg::VALUE_WIDTH_DEFAULT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] entry_mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port; the read data holds
  // while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      entry_mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= entry_mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/qsls_ctrl.sv */
`default_nettype none

module qsls_ctrl #(
  parameter int DEPTH       = qsls_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = qsls_pkg::VALUE_WIDTH_DEFAULT,
  localparam int AW         = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [qsls_pkg::OP_W-1:0]   in_op,
  input  wire logic [qsls_pkg::DATA_W-1:0] in_data_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output qsls_pkg::result_t                out_res,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic [VALUE_WIDTH-1:0]           mem_wdata,
  output logic                             mem_re,
  output logic [AW-1:0]                    mem_raddr,
  input  wire logic [VALUE_WIDTH-1:0]      mem_rdata
);

  import qsls_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SHIFT} state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          front_r, front_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   rev_r, rev_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_res_r, out_res_nxt;

  logic                   fin;
  result_t                fin_res;
  logic                   out_free;
  logic [AW-1:0]          front_inc;
  logic [AW-1:0]          front_dec;
  logic [CW-1:0]          pos_p1;
  logic [CW-1:0]          pos_p2;

  // Physical slot of a logical position, with the run read backward when
  // the direction flag is set.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                             input logic [CW-1:0] cnt,
                                             input logic          rev,
                                             input logic [CW-1:0] pos);
    logic [CW-1:0] off;
    logic [AW:0]   sum;
    off = rev ? (cnt - pos - CW'(1)) : pos;
    sum = {1'b0, front} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign pos_p1    = pos_r + CW'(1);
  assign pos_p2    = pos_r + CW'(2);

  // Sequencer: one read or read-modify-write step per cycle, while not stalled.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    fin           = 1'b0;
    fin_res       = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = val_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        // Take the item and read the entry that it will most likely need.
        if (in_valid) begin
          op_nxt    = in_op;
          val_nxt   = VALUE_WIDTH'(in_data_value);
          pos_nxt   = '0;
          state_nxt = S_EXEC;
          mem_re    = (count_r != '0);
          if (in_op == OP_TAKE_BACK) begin
            mem_raddr = slot_of(front_r, count_r, rev_r, count_r - CW'(1));
          end else begin
            mem_raddr = slot_of(front_r, count_r, rev_r, '0);
          end
        end
      end

      S_EXEC: begin
        case (op_r)
          OP_APPEND: begin
            fin = 1'b1;
            if (count_r == CW'(DEPTH)) begin
              fin_res.status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
              if (rev_r) begin
                mem_waddr = front_dec;
                front_nxt = front_dec;
              end else begin
                mem_waddr = slot_of(front_r, count_r, 1'b0, count_r);
              end
            end
          end

          OP_TAKE_FRONT, OP_TAKE_BACK: begin
            fin = 1'b1;
            if (count_r == '0) begin
              fin_res.status = ST_EMPTY;
            end else begin
              fin_res.value = DATA_W'(mem_rdata);
              count_nxt     = count_r - CW'(1);
              // The low physical end moves when the logical end taken sits there.
              if ((op_r == OP_TAKE_FRONT) != rev_r) begin
                front_nxt = front_inc;
              end
            end
          end

          OP_REMOVE: begin
            // Scan: the read data belongs to logical position pos_r.
            if (count_r == '0) begin
              fin            = 1'b1;
              fin_res.status = ST_EMPTY;
            end else if (mem_rdata == val_r) begin
              if (pos_p1 == count_r) begin
                fin           = 1'b1;
                fin_res.value = DATA_W'(val_r);
                count_nxt     = count_r - CW'(1);
                if (rev_r) begin
                  front_nxt = front_inc;
                end
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(front_r, count_r, rev_r, pos_p1);
                state_nxt = S_SHIFT;
              end
            end else if (pos_p1 == count_r) begin
              fin            = 1'b1;
              fin_res.status = ST_NOT_FOUND;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot_of(front_r, count_r, rev_r, pos_p1);
              pos_nxt   = pos_p1;
            end
          end

          OP_REVERSE: begin
            fin     = 1'b1;
            rev_nxt = !rev_r;
          end

          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_SHIFT: begin
        // Move the entry one position toward the front; the read issued runs two
        // positions ahead of the write, so they never meet on one slot.
        mem_we    = 1'b1;
        mem_waddr = slot_of(front_r, count_r, rev_r, pos_r);
        mem_wdata = mem_rdata;
        if (pos_p2 == count_r) begin
          fin           = 1'b1;
          fin_res.value = DATA_W'(val_r);
          count_nxt     = count_r - CW'(1);
          if (rev_r) begin
            front_nxt = front_inc;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(front_r, count_r, rev_r, pos_p2);
          pos_nxt   = pos_p1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    fin_res.count = COUNT_W'(count_nxt);

    // Output register: a finished result enters when the slot is free.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = fin_res;
        state_nxt     = S_IDLE;
      end else begin
        // Hold the last step until the result can leave; the read data
        // register keeps its value since no read is issued.
        state_nxt = state_r;
        front_nxt = front_r;
        count_nxt = count_r;
        rev_nxt   = rev_r;
        pos_nxt   = pos_r;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

/* src/queue_stack_list_store.sv */
`default_nettype none

// Channel  Ports                                                  Direction
// input    in_valid, in_stall, in_op, in_data_value               in
// result   out_valid, out_stall, out_result_value, out_status,    out
//          out_entry_count
//
// Append, take front, take back, reverse and unused codes finish with the
// transfer and one execute step. Remove scans and then shifts entries
// through the single read port of the entry memory, one position per cycle,
// and takes one execute step on an empty store.
// Reset is synchronous and active low; the entry memory is not cleared.
// A stalled result holds the last step of the next item until it leaves.

module queue_stack_list_store #(
  parameter int DEPTH       = qsls_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = qsls_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [qsls_pkg::OP_W-1:0]     in_op,
  input  wire logic [qsls_pkg::DATA_W-1:0]   in_data_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [qsls_pkg::DATA_W-1:0]        out_result_value,
  output logic [qsls_pkg::STATUS_W-1:0]      out_status,
  output logic [qsls_pkg::COUNT_W-1:0]       out_entry_count
);

  import qsls_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  result_t                out_res;

  // Sequencer with the store's pointers and the result register.
  qsls_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_data_value (in_data_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  // Entry memory.
  qsls_mem #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_result_value = out_res.value;
  assign out_status       = out_res.status;
  assign out_entry_count  = out_res.count;

endmodule

`default_nettype wire

/* src/qsls_check.sv */
`default_nettype none

module qsls_check #(
  parameter int DEPTH = qsls_pkg::DEPTH_DEFAULT
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [qsls_pkg::DATA_W-1:0]   out_result_value,
  input wire logic [qsls_pkg::STATUS_W-1:0] out_status,
  input wire logic [qsls_pkg::COUNT_W-1:0]  out_entry_count
);

  import qsls_pkg::*;

  // A stalled result keeps its whole payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value) &&
      $stable(out_status) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // Each item is worked on alone: the input stalls right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // An empty status leaves nothing held and returns no value.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_result_value == '0 && out_entry_count == '0)
    else $error("empty status with value or entries");

  // A dropped append reports a full store.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_entry_count == COUNT_W'(DEPTH) && out_result_value == '0)
    else $error("full status with wrong count or value");

  // A failed search returns no value.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_FOUND |-> out_result_value == '0)
    else $error("not found status with a value");

endmodule

bind queue_stack_list_store qsls_check #(.DEPTH(DEPTH)) u_check (.*);

`default_nettype wire
